// ===== rtl/bfha_pkg.sv =====
`default_nettype none
package bfha_pkg;

	localparam int unsigned HEAP_BYTES_DEF = 65536;
	localparam logic [16:0] HEAP_SIZE_RST  = 17'd65536;
	localparam logic [31:0] MIN_BLOCK      = 32'd16;
	localparam logic [31:0] TAG_MASK       = ~32'd7;
	localparam logic [31:0] LINK_VALID     = 32'h8000_0000;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic ST_DONE  = 1'b0;
	localparam logic ST_NOFIT = 1'b1;

	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_SIZE = 1'b1;

	// One memory access per cycle; reads return data on the next cycle
	typedef struct packed {
		logic        we;
		logic [31:0] off;
		logic [31:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic [31:0] address;
		logic        status;
	} res_t;

	typedef enum logic [5:0] {
		S_CLEAR, S_INIT_H, S_INIT_F, S_IDLE, S_DONE,
		S_WCHK, S_WHDR, S_WNXT, S_AEND,
		S_SP_RN, S_SP_RP, S_SP_W1, S_SP_W2, S_SP_W3, S_SP_W4,
		S_SP_W5, S_SP_W6, S_SP_W7, S_SP_W8,
		S_NS_RH, S_NS_WH,
		S_UL_RN, S_UL_RP, S_UL_W1, S_UL_W2,
		S_F_CHK, S_F_HDR, S_F_NX, S_F_NH, S_F_PV, S_F_FS, S_F_PH,
		S_F_W1, S_F_W2, S_F_W3, S_F_W4, S_F_W5
	} state_t;

	// Block start lies inside the heap, 8-byte aligned, with room for a minimum block
	function automatic logic block_ok(input logic [31:0] off, input logic [31:0] eff);
		return (off < eff) && (off[2:0] == 3'd0) && ((eff - off) >= MIN_BLOCK);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bfha_ram.sv =====
`default_nettype none
module bfha_ram #(
	parameter int unsigned HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire bfha_pkg::mem_req_t req,
	output logic [31:0]             rdata
);
	import bfha_pkg::*;

	localparam int unsigned WORDS = HEAP_BYTES / 4;
	localparam int unsigned AW    = $clog2(WORDS);

	logic [31:0]   mem [WORDS];
	logic [AW-1:0] addr;

	// Word index takes offset bits [AW+1:2], so it wraps modulo 2**AW words
	assign addr = req.off[AW+1:2];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== rtl/bfha_engine.sv =====
`default_nettype none
module bfha_engine #(
	parameter int unsigned HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               size_we,
	input  wire logic [16:0]        size_data,
	input  wire logic [31:0]        base,
	input  wire logic               in_take,
	input  wire logic               operation,
	input  wire logic [16:0]        request_bytes,
	input  wire logic [31:0]        free_address,
	output logic                    idle,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output bfha_pkg::res_t          res,
	output bfha_pkg::mem_req_t      mem_req,
	input  wire logic [31:0]        mem_rdata
);
	import bfha_pkg::*;

	localparam int unsigned WORDS      = HEAP_BYTES / 4;
	localparam int unsigned AW         = $clog2(WORDS);
	localparam int unsigned EW         = $clog2(HEAP_BYTES) + 1;
	localparam int unsigned WALK_LIMIT = HEAP_BYTES / 16 + 1;
	localparam int unsigned SW         = $clog2(WALK_LIMIT + 1);

	state_t        state_q, state_d, ret_q;
	logic [AW-1:0] clr_q;
	logic [EW-1:0] eff_q;
	logic [30:0]   first_q;
	logic          first_vld_q;

	logic [31:0]   link_q, need_q, off_q, best_q, bsize_q, size_q, ul_q, n_q, p_q;
	logic [SW-1:0] steps_q;
	logic          found_q, fzero_q;
	res_t          res_q;

	logic [31:0] eff, head_link, w_off, tag, nb, rem, nx, req_r;
	logic        walk_go, fit, split, f_bad, f_hdr_ok, f_nx_ok, f_nh_ok, f_fs_ok, f_ph_ok;

	// Clamp to the heap and round down to 8 bytes
	function automatic logic [EW-1:0] eff_of(input logic [16:0] s);
		logic [31:0] c;
		c = ({15'd0, s} > 32'(HEAP_BYTES)) ? 32'(HEAP_BYTES) : {15'd0, s};
		return EW'(c & TAG_MASK);
	endfunction

	assign eff       = 32'(eff_q);
	assign head_link = first_vld_q ? {1'b1, first_q} : 32'd0;
	assign w_off     = {1'b0, link_q[30:0]};
	assign tag       = mem_rdata & TAG_MASK;
	assign walk_go   = (32'(steps_q) < 32'(WALK_LIMIT)) && link_q[31] && block_ok(w_off, eff);
	assign fit       = (tag >= need_q) && (tag <= eff - off_q) && (!found_q || tag < bsize_q);
	assign rem       = bsize_q - need_q;
	assign split     = rem >= MIN_BLOCK;
	assign nb        = best_q + need_q;
	assign nx        = off_q + size_q;
	assign f_bad     = fzero_q || !block_ok(off_q, eff);
	assign f_hdr_ok  = mem_rdata[0] && (tag >= MIN_BLOCK) && (tag <= eff - off_q);
	assign f_nx_ok   = block_ok(nx, eff);
	assign f_nh_ok   = !mem_rdata[0] && (tag >= MIN_BLOCK) && (tag <= eff - ul_q);
	assign f_fs_ok   = (tag >= MIN_BLOCK) && (tag <= off_q);
	assign f_ph_ok   = !mem_rdata[0] && (tag == bsize_q);
	assign req_r     = ({15'd0, request_bytes} + 32'd7) & TAG_MASK;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (clr_q == AW'(WORDS - 1)) state_d = S_INIT_H;
			S_INIT_H: state_d = (eff >= MIN_BLOCK) ? S_INIT_F : S_IDLE;
			S_INIT_F: state_d = S_IDLE;
			S_IDLE: begin
				if (in_take) state_d = (operation == OP_ALLOC) ? S_WCHK : S_F_CHK;
			end
			S_DONE:   if (res_ready) state_d = S_IDLE;
			S_WCHK:   state_d = walk_go ? S_WHDR : S_AEND;
			S_WHDR:   state_d = S_WNXT;
			S_WNXT:   state_d = S_WCHK;
			S_AEND: begin
				if (!found_q) state_d = S_DONE;
				else if (split) state_d = S_SP_RN;
				else state_d = S_NS_RH;
			end
			S_SP_RN:  state_d = S_SP_RP;
			S_SP_RP:  state_d = S_SP_W1;
			S_SP_W1:  state_d = S_SP_W2;
			S_SP_W2:  state_d = S_SP_W3;
			S_SP_W3:  state_d = S_SP_W4;
			S_SP_W4:  state_d = S_SP_W5;
			S_SP_W5:  state_d = S_SP_W6;
			S_SP_W6:  state_d = S_SP_W7;
			S_SP_W7:  state_d = S_SP_W8;
			S_SP_W8:  state_d = S_DONE;
			S_NS_RH:  state_d = S_NS_WH;
			S_NS_WH:  state_d = S_UL_RN;
			S_UL_RN:  state_d = S_UL_RP;
			S_UL_RP:  state_d = S_UL_W1;
			S_UL_W1:  state_d = S_UL_W2;
			S_UL_W2:  state_d = ret_q;
			S_F_CHK:  state_d = f_bad ? S_DONE : S_F_HDR;
			S_F_HDR:  state_d = f_hdr_ok ? S_F_NX : S_DONE;
			S_F_NX:   state_d = f_nx_ok ? S_F_NH : S_F_PV;
			S_F_NH:   state_d = f_nh_ok ? S_UL_RN : S_F_PV;
			S_F_PV:   state_d = (off_q >= MIN_BLOCK) ? S_F_FS : S_F_W1;
			S_F_FS:   state_d = f_fs_ok ? S_F_PH : S_F_W1;
			S_F_PH:   state_d = f_ph_ok ? S_UL_RN : S_F_W1;
			S_F_W1:   state_d = S_F_W2;
			S_F_W2:   state_d = S_F_W3;
			S_F_W3:   state_d = S_F_W4;
			S_F_W4:   state_d = S_F_W5;
			S_F_W5:   state_d = S_DONE;
			default:  state_d = S_IDLE;
		endcase
		if (size_we) state_d = S_CLEAR;
	end

	// Memory access for each state
	always_comb begin
		mem_req = '{we: 1'b0, off: 32'd0, wdata: 32'd0};
		case (state_q)
			S_CLEAR:  mem_req = '{1'b1, {(32 - AW - 2)'(0), clr_q, 2'b00}, 32'd0};
			S_INIT_H: mem_req = '{eff >= MIN_BLOCK, 32'd0, eff};
			S_INIT_F: mem_req = '{1'b1, eff - 32'd4, eff};
			S_WCHK:   mem_req.off = w_off;
			S_WHDR:   mem_req.off = off_q + 32'd4;
			S_SP_RN:  mem_req.off = best_q + 32'd4;
			S_SP_RP:  mem_req.off = best_q + 32'd8;
			S_SP_W1:  mem_req = '{1'b1, nb, rem};
			S_SP_W2:  mem_req = '{1'b1, nb + rem - 32'd4, rem};
			S_SP_W3:  mem_req = '{1'b1, nb + 32'd4, n_q};
			S_SP_W4:  mem_req = '{1'b1, nb + 32'd8, p_q};
			S_SP_W5:  mem_req = '{p_q[31], {1'b0, p_q[30:0]} + 32'd4, nb | LINK_VALID};
			S_SP_W6:  mem_req = '{n_q[31], {1'b0, n_q[30:0]} + 32'd8, nb | LINK_VALID};
			S_SP_W7:  mem_req = '{1'b1, best_q, need_q | 32'd1};
			S_SP_W8:  mem_req = '{1'b1, best_q + need_q - 32'd4, need_q | 32'd1};
			S_NS_RH:  mem_req.off = best_q;
			S_NS_WH:  mem_req = '{1'b1, best_q, mem_rdata | 32'd1};
			S_UL_RN:  mem_req.off = ul_q + 32'd4;
			S_UL_RP:  mem_req.off = ul_q + 32'd8;
			S_UL_W1:  mem_req = '{mem_rdata[31], {1'b0, mem_rdata[30:0]} + 32'd4, n_q};
			S_UL_W2:  mem_req = '{n_q[31], {1'b0, n_q[30:0]} + 32'd8, p_q};
			S_F_CHK:  mem_req.off = off_q;
			S_F_HDR:  mem_req = '{f_hdr_ok, off_q, tag};
			S_F_NX:   mem_req.off = nx;
			S_F_PV:   mem_req.off = off_q - 32'd4;
			S_F_FS:   mem_req.off = off_q - tag;
			S_F_W1:   mem_req = '{1'b1, off_q, size_q};
			S_F_W2:   mem_req = '{1'b1, off_q + size_q - 32'd4, size_q};
			S_F_W3:   mem_req = '{1'b1, off_q + 32'd4, head_link};
			S_F_W4:   mem_req = '{1'b1, off_q + 32'd8, 32'd0};
			S_F_W5:   mem_req = '{first_vld_q, {1'b0, first_q} + 32'd8, off_q | LINK_VALID};
			default:  mem_req = '{we: 1'b0, off: 32'd0, wdata: 32'd0};
		endcase
	end

	// Control state: sequencer, clear sweep, heap extent, list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			eff_q       <= eff_of(HEAP_SIZE_RST);
			first_q     <= '0;
			first_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			case (state_q)
				S_INIT_H: begin
					first_q     <= '0;
					first_vld_q <= eff >= MIN_BLOCK;
				end
				S_SP_W6: begin
					if (first_vld_q && {1'b0, first_q} == best_q) first_q <= nb[30:0];
				end
				S_UL_W2: begin
					if (first_vld_q && {1'b0, first_q} == ul_q) begin
						first_vld_q <= n_q[31];
						first_q     <= n_q[31] ? n_q[30:0] : 31'd0;
					end
				end
				S_F_W5: begin
					first_vld_q <= 1'b1;
					first_q     <= off_q[30:0];
				end
				default: ;
			endcase
			if (size_we) begin
				clr_q <= '0;
				eff_q <= eff_of(size_data);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					need_q  <= ((req_r < 32'd8) ? 32'd8 : req_r) + 32'd8;
					link_q  <= head_link;
					steps_q <= '0;
					found_q <= 1'b0;
					off_q   <= free_address - base - 32'd4;
					fzero_q <= free_address == 32'd0;
					res_q   <= '{32'd0, ST_DONE};
				end
			end
			S_WCHK:  off_q <= w_off;
			S_WHDR: begin
				if (fit) begin
					best_q  <= off_q;
					bsize_q <= tag;
					found_q <= 1'b1;
				end
			end
			S_WNXT: begin
				link_q  <= mem_rdata;
				steps_q <= steps_q + SW'(1);
			end
			S_AEND: begin
				if (!found_q) res_q <= '{32'd0, ST_NOFIT};
				else res_q <= '{base + best_q + 32'd4, ST_DONE};
			end
			S_SP_RP: n_q <= mem_rdata;
			S_SP_W1: p_q <= mem_rdata;
			S_NS_RH: begin
				ul_q  <= best_q;
				ret_q <= S_DONE;
			end
			S_UL_RP: n_q <= mem_rdata;
			S_UL_W1: p_q <= mem_rdata;
			S_F_HDR: size_q <= tag;
			S_F_NX:  ul_q <= nx;
			S_F_NH: begin
				if (f_nh_ok) size_q <= size_q + tag;
				ret_q <= S_F_PV;
			end
			S_F_FS: begin
				bsize_q <= tag;
				ul_q    <= off_q - tag;
			end
			S_F_PH: begin
				if (f_ph_ok) begin
					size_q <= size_q + bsize_q;
					off_q  <= ul_q;
				end
				ret_q <= S_F_W1;
			end
			default: ;
		endcase
	end

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !size_we |=> state_q != S_IDLE)
		else $error("accepted beat did not start work");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_req.we)
		else $error("heap write while idle");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready && !size_we |=> res_valid && $stable(res_q))
		else $error("result dropped before it was taken");

endmodule
`default_nettype wire

// ===== rtl/best_fit_heap_allocator.sv =====
`default_nettype none
// Channel  Direction  Handshake           Payload
// cfg      in         cfg_we              cfg_index, cfg_data
// in       in         in_valid/in_stall   operation, request_bytes, free_address
// out      out        out_valid/out_stall address, status
//
// Each beat is handled alone by a sequencer around one single-port heap memory.
// An allocate walks the free list entry by entry for the best fit, then splits it or
// unlinks it whole; a free checks the block, merges it with free neighbours and pushes
// it onto the list head. Memory latency and the single port pace these steps.
// Reset and each heap_size write clear HEAP_BYTES/4 words, one per cycle, then
// write the initial tags; no beat is accepted meanwhile.
// A finished result sits in the output register, so a stalled output holds the
// next result back in the engine, which then takes no new beat.
module best_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [16:0] request_bytes,
	input  wire logic [31:0] free_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      address,
	output logic             status
);
	import bfha_pkg::*;

	logic        base_we, size_we, idle, in_take, res_valid, res_ready;
	logic [31:0] base_q, mem_rdata;
	res_t        res, out_q;
	logic        out_valid_q;
	mem_req_t    mem_req;

	assign base_we   = cfg_we && (cfg_index == REG_HEAP_BASE);
	assign size_we   = cfg_we && (cfg_index == REG_HEAP_SIZE);
	assign in_stall  = !idle;
	assign in_take   = in_valid && idle;
	assign res_ready = !out_valid_q || !out_stall;

	// Hold the heap base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (base_we) begin
			base_q <= cfg_data;
		end
	end

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign address   = out_q.address;
	assign status    = out_q.status;

	bfha_engine #(.HEAP_BYTES(HEAP_BYTES)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.size_we      (size_we),
		.size_data    (cfg_data[16:0]),
		.base         (base_q),
		.in_take      (in_take),
		.operation    (operation),
		.request_bytes(request_bytes),
		.free_address (free_address),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	bfha_ram #(.HEAP_BYTES(HEAP_BYTES)) u_ram (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import bfha_pkg::*;

	localparam int WORDS = 16384;
	localparam int QUIET_LIMIT = 60000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic        op;
		logic [16:0] req;
		logic [31:0] fa;
		bit          typed;
		logic [31:0] ea;
		logic        es;
	} vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_HEAP_BASE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_ALLOC;
	logic [16:0] request_bytes = '0;
	logic [31:0] free_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] address;
	logic        status;

	best_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_bytes(request_bytes), .free_address(free_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.address(address), .status(status)
	);

	always #10 clk = ~clk;

	// Allocator shadow state
	logic [31:0] hmem [0:WORDS-1];
	logic [31:0] m_base, m_eff, m_head;
	logic [16:0] m_size;
	bit          m_head_ok;

	res_t        pending_res[$];
	logic [31:0] live_addr[$];
	logic [31:0] last_freed;
	int          err_count, snd_pct, rcv_pct, hold_req, quiet;
	int          n_beats_in, n_beats_out, n_nofit, n_frees;

	function automatic logic [31:0] hrd(input logic [31:0] off);
		return hmem[off[15:2]];
	endfunction

	function automatic void hwr(input logic [31:0] off, input logic [31:0] v);
		hmem[off[15:2]] = v;
	endfunction

	function automatic bit blk_ok(input logic [31:0] off);
		return off < m_eff && off[2:0] == 3'd0 && (m_eff - off) >= MIN_BLOCK;
	endfunction

	function automatic logic [31:0] head_lnk();
		return m_head_ok ? (m_head | LINK_VALID) : 32'd0;
	endfunction

	function automatic void set_head(input logic [31:0] l);
		m_head_ok = l[31];
		m_head = l[31] ? {1'b0, l[30:0]} : 32'd0;
	endfunction

	function automatic void list_remove(input logic [31:0] off);
		logic [31:0] n, p;
		n = hrd(off + 4);
		p = hrd(off + 8);
		if (p[31]) hwr({1'b0, p[30:0]} + 4, n);
		if (n[31]) hwr({1'b0, n[30:0]} + 8, p);
		if (m_head_ok && m_head == off) set_head(n);
	endfunction

	function automatic void heap_reinit();
		logic [31:0] s;
		s = (m_size > 17'd65536) ? 32'd65536 : 32'(m_size);
		m_eff = s & TAG_MASK;
		for (int i = 0; i < WORDS; i++) hmem[i] = '0;
		if (m_eff >= MIN_BLOCK) begin
			hwr(0, m_eff);
			hwr(m_eff - 4, m_eff);
			hwr(4, 0);
			hwr(8, 0);
			set_head(LINK_VALID);
		end else begin
			set_head(0);
		end
	endfunction

	function automatic res_t predict_alloc(input logic [16:0] req);
		logic [31:0] need, lnk, best, bsize, off, cs, rem, nb, n, p;
		bit found;
		res_t r;
		need = (32'(req) + 7) & TAG_MASK;
		if (need < 8) need = 8;
		need += 8;
		lnk = head_lnk();
		found = 0;
		best = 0;
		bsize = 0;
		for (int steps = 0; steps < WORDS / 4 + 1 && lnk[31]; steps++) begin
			off = {1'b0, lnk[30:0]};
			if (!blk_ok(off)) break;
			cs = hrd(off) & TAG_MASK;
			if (cs >= need && cs <= m_eff - off && (!found || cs < bsize)) begin
				best = off;
				bsize = cs;
				found = 1;
			end
			lnk = hrd(off + 4);
		end
		if (!found) begin
			r.address = 0;
			r.status = ST_NOFIT;
			return r;
		end
		if (bsize - need >= MIN_BLOCK) begin
			rem = bsize - need;
			nb = best + need;
			n = hrd(best + 4);
			p = hrd(best + 8);
			hwr(nb, rem);
			hwr(nb + rem - 4, rem);
			hwr(nb + 4, n);
			hwr(nb + 8, p);
			if (p[31]) hwr({1'b0, p[30:0]} + 4, nb | LINK_VALID);
			if (n[31]) hwr({1'b0, n[30:0]} + 8, nb | LINK_VALID);
			if (m_head_ok && m_head == best) set_head(nb | LINK_VALID);
			hwr(best, need | 1);
			hwr(best + need - 4, need | 1);
		end else begin
			hwr(best, hrd(best) | 1);
			list_remove(best);
		end
		r.address = m_base + best + 4;
		r.status = ST_DONE;
		return r;
	endfunction

	function automatic void predict_free(input logic [31:0] fa);
		logic [31:0] off, hdr, size, nx, nh, ns, fs, p, ph;
		if (fa == 0) return;
		off = fa - m_base - 4;
		if (!blk_ok(off)) return;
		hdr = hrd(off);
		size = hdr & TAG_MASK;
		if (!hdr[0] || size < MIN_BLOCK || size > m_eff - off) return;
		hwr(off, size);
		// merge forward
		nx = off + size;
		if (nx < m_eff && blk_ok(nx)) begin
			nh = hrd(nx);
			ns = nh & TAG_MASK;
			if (!nh[0] && ns >= MIN_BLOCK && ns <= m_eff - nx) begin
				size += ns;
				list_remove(nx);
			end
		end
		// merge backward
		if (off >= MIN_BLOCK) begin
			fs = hrd(off - 4) & TAG_MASK;
			if (fs >= MIN_BLOCK && fs <= off) begin
				p = off - fs;
				ph = hrd(p);
				if (!ph[0] && (ph & TAG_MASK) == fs) begin
					size += fs;
					list_remove(p);
					off = p;
				end
			end
		end
		hwr(off, size);
		hwr(off + size - 4, size);
		hwr(off + 4, head_lnk());
		hwr(off + 8, 0);
		if (m_head_ok) hwr(m_head + 8, off | LINK_VALID);
		set_head(off | LINK_VALID);
	endfunction

	// Offer one beat, hold it until accepted, then record its expected result
	task automatic send_beat(input logic op, input logic [16:0] req, input logic [31:0] fa,
			input bit typed = 0, input logic [31:0] ea = 0, input logic es = 0);
		res_t r;
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_bytes <= req;
		free_address <= fa;
		do @(posedge clk); while (in_stall);
		n_beats_in++;
		if (op == OP_ALLOC) begin
			r = predict_alloc(req);
			if (r.status == ST_NOFIT) n_nofit++;
			else if (r.address != 0) live_addr.push_back(r.address);
		end else begin
			predict_free(fa);
			r.address = 0;
			r.status = ST_DONE;
			n_frees++;
		end
		if (typed) begin
			r.address = ea;
			r.status = es;
		end
		pending_res.push_back(r);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register while idle
	task automatic cfg_write(input logic idx, input logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEAP_BASE) begin
			m_base = v;
		end else begin
			m_size = v[16:0];
			heap_reinit();
			live_addr.delete();
		end
	endtask

	function automatic logic [16:0] pick_req();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 17'($urandom_range(64));
		if (r < 90) return 17'($urandom_range(1024));
		if (r < 97) return 17'($urandom_range(8192));
		return 17'($urandom_range(131071));
	endfunction

	// Mostly well-formed alloc/free traffic with some bad frees mixed in
	task automatic random_beats(input int n, input int hold_at, input int pause_at);
		int r, k;
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at) hold_req = 400;
			if (i == pause_at) begin
				drop_valid();
				while (pending_res.size() != 0) @(posedge clk);
			end
			r = $urandom_range(99);
			if (live_addr.size() == 0 || r < 55) begin
				send_beat(OP_ALLOC, pick_req(), $urandom);
			end else if (r < 90) begin
				k = $urandom_range(live_addr.size() - 1);
				a = live_addr[k];
				live_addr.delete(k);
				last_freed = a;
				send_beat(OP_FREE, pick_req(), a);
			end else if (r < 95) begin
				send_beat(OP_FREE, pick_req(), last_freed);
			end else begin
				a = $urandom;
				if (r < 97) a = (m_base + (a & 32'hFFFF)) | 32'd4;
				send_beat(OP_FREE, pick_req(), a);
			end
		end
		drop_valid();
	endtask

	// Receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		int hold_left;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_pct);
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_beats_out++;
			if (pending_res.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result beat: address %h status %b", address, status);
			end else begin
				e = pending_res.pop_front();
				if (e.address !== address || e.status !== status) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: expected address %h status %b, got %h %b",
							e.address, e.status, address, status);
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	vec_t dir_tab[$];

	initial begin
		m_base = 0;
		m_size = HEAP_SIZE_RST;
		heap_reinit();
		last_freed = 0;
		snd_pct = 13;
		rcv_pct = 85;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on the reset heap
		dir_tab = '{
			'{OP_ALLOC, 17'd0, 32'd0, 1, 32'd4, ST_DONE},
			'{OP_ALLOC, 17'd1, 32'd0, 1, 32'd20, ST_DONE},
			'{OP_ALLOC, 17'd8, 32'd0, 1, 32'd36, ST_DONE},
			'{OP_ALLOC, 17'd65536, 32'd0, 1, 32'd0, ST_NOFIT},
			'{OP_FREE, 17'd0, 32'd0, 1, 32'd0, ST_DONE},
			'{OP_FREE, 17'd0, 32'd20, 1, 32'd0, ST_DONE},
			'{OP_FREE, 17'd0, 32'd20, 1, 32'd0, ST_DONE},
			'{OP_FREE, 17'd0, 32'd3, 1, 32'd0, ST_DONE},
			'{OP_FREE, 17'h1FFFF, 32'hFFFF_FFFF, 1, 32'd0, ST_DONE},
			'{OP_ALLOC, 17'd8, 32'd0, 1, 32'd20, ST_DONE},
			'{OP_FREE, 17'd0, 32'd4, 1, 32'd0, ST_DONE},
			'{OP_FREE, 17'd0, 32'd36, 1, 32'd0, ST_DONE},
			'{OP_FREE, 17'd0, 32'd20, 1, 32'd0, ST_DONE},
			'{OP_ALLOC, 17'd65528, 32'd0, 1, 32'd4, ST_DONE},
			'{OP_ALLOC, 17'd0, 32'd0, 1, 32'd0, ST_NOFIT},
			'{OP_FREE, 17'd0, 32'd4, 1, 32'd0, ST_DONE},
			'{OP_ALLOC, 17'd65529, 32'd0, 1, 32'd0, ST_NOFIT},
			'{OP_ALLOC, 17'h1FFFF, 32'd0, 1, 32'd0, ST_NOFIT},
			'{OP_ALLOC, 17'd200, 32'd0, 0, 32'd0, ST_DONE},
			'{OP_ALLOC, 17'd13, 32'd0, 0, 32'd0, ST_DONE},
			'{OP_FREE, 17'd0, 32'd4, 0, 32'd0, ST_DONE},
			'{OP_ALLOC, 17'd100, 32'd0, 0, 32'd0, ST_DONE}
		};
		foreach (dir_tab[i])
			send_beat(dir_tab[i].op, dir_tab[i].req, dir_tab[i].fa,
				dir_tab[i].typed, dir_tab[i].ea, dir_tab[i].es);
		drop_valid();
		live_addr.delete();
		random_beats(250, -1, -1);

		// small heap, random base, busy receiver flipped to busy sender
		snd_pct = 85;
		rcv_pct = 13;
		cfg_write(REG_HEAP_BASE, $urandom);
		cfg_write(REG_HEAP_SIZE, 32'($urandom_range(64, 512)) * 8);
		random_beats(250, -1, -1);

		// minimum heap with a base that wraps the payload address to zero
		snd_pct = 0;
		rcv_pct = 0;
		cfg_write(REG_HEAP_BASE, 32'hFFFF_FFFC);
		cfg_write(REG_HEAP_SIZE, 32'd16);
		send_beat(OP_ALLOC, 17'd0, 32'd0, 1, 32'd0, ST_DONE);
		send_beat(OP_FREE, 17'd0, 32'd0, 1, 32'd0, ST_DONE);
		send_beat(OP_ALLOC, 17'd0, 32'd0, 1, 32'd0, ST_NOFIT);
		drop_valid();
		cfg_write(REG_HEAP_BASE, 32'hFFFF_FFF0);
		cfg_write(REG_HEAP_SIZE, 32'd16);
		send_beat(OP_ALLOC, 17'd8, 32'd0, 1, 32'hFFFF_FFF4, ST_DONE);
		send_beat(OP_FREE, 17'd0, 32'hFFFF_FFF4, 1, 32'd0, ST_DONE);
		send_beat(OP_ALLOC, 17'd9, 32'd0, 1, 32'd0, ST_NOFIT);
		drop_valid();

		// heap too small to hold any block
		cfg_write(REG_HEAP_SIZE, 32'd15);
		send_beat(OP_ALLOC, 17'd0, 32'd0, 1, 32'd0, ST_NOFIT);
		send_beat(OP_FREE, 17'd0, 32'hFFFF_FFF4, 1, 32'd0, ST_DONE);
		drop_valid();

		// oversized heap_size clamps to the full heap; hold off and pause
		cfg_write(REG_HEAP_BASE, $urandom);
		cfg_write(REG_HEAP_SIZE, 32'h1FFFF);
		random_beats(370, 100, 250);

		drain();
		$display("Covered %0d input beats and %0d result beats: %0d frees, %0d no-fit allocs,",
			n_beats_in, n_beats_out, n_frees, n_nofit);
		$display("over five heap settings from no block to the clamped full heap.");
		if (err_count == 0 && pending_res.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bfha_pkg.sv
rtl/bfha_ram.sv
rtl/bfha_engine.sv
rtl/best_fit_heap_allocator.sv
tb/sv/tb_top.sv
